### rtl/core/shp_pkg.sv
// Shared types, constants and helper functions for the stepper heading positioner.
package shp_pkg;

    // Heading arithmetic
    localparam int unsigned FULL_TURN_DEF   = 32400;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned MOD_STEPS       = 7;      // covers inputs below 128 * turn
    localparam logic [15:0] DEG_SCALE       = 16'd90; // 1/90 degree units per degree

    // Configuration reset
    localparam logic [13:0] STEP_ANGLE_RST = 14'd70;

    // Dwell codes
    localparam logic [4:0] DWELL_NONE = 5'd0;
    localparam logic [4:0] DWELL_FAST = 5'd8;
    localparam logic [4:0] DWELL_SLOW = 5'd20;

    // Joystick X ranges
    localparam logic [9:0] JOY_CCW_SLOW_LO = 10'h27F;
    localparam logic [9:0] JOY_CCW_SLOW_HI = 10'h2FF;
    localparam logic [9:0] JOY_CW_SLOW_LO  = 10'h100;
    localparam logic [9:0] JOY_CW_SLOW_HI  = 10'h180;

    // Command codes
    localparam logic CMD_SEEK = 1'b0;
    localparam logic CMD_JOY  = 1'b1;

    // Coil drive codes
    localparam logic [3:0] COIL_OFF = 4'h0;
    localparam logic [3:0] COIL_A   = 4'h1;
    localparam logic [3:0] COIL_B   = 4'h2;
    localparam logic [3:0] COIL_C   = 4'h4;
    localparam logic [3:0] COIL_D   = 4'h8;

    localparam int unsigned PHASES = 4;
    localparam logic [1:0]  PHASE_LAST = 2'(PHASES - 1);

    // One classified item, front to back
    typedef struct packed {
        logic        is_step;
        logic        cw;
        logic [4:0]  dwell;
        logic [14:0] heading;
        logic        arrived;
    } t_step_req;

    // Restoring reduction of x modulo m, x below 128 * m
    function automatic logic [15:0] mod_reduce(input logic [15:0] x, input logic [15:0] m);
        logic [22:0] acc;
        logic [22:0] sub;
        acc = {7'b0, x};
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            sub = {7'b0, m} << k;
            if (acc >= sub) begin
                acc = acc - sub;
            end
        end
        return acc[15:0];
    endfunction

    // Coil pattern for a phase: clockwise D A B C, counter-clockwise C B A D
    function automatic logic [3:0] coil_seq(input logic cw, input logic [1:0] phase);
        logic [3:0] coil;
        if (cw) begin
            unique case (phase)
                2'd0: coil = COIL_D;
                2'd1: coil = COIL_A;
                2'd2: coil = COIL_B;
                2'd3: coil = COIL_C;
                default: coil = COIL_OFF;
            endcase
        end else begin
            unique case (phase)
                2'd0: coil = COIL_C;
                2'd1: coil = COIL_B;
                2'd2: coil = COIL_A;
                2'd3: coil = COIL_D;
                default: coil = COIL_OFF;
            endcase
        end
        return coil;
    endfunction

endpackage

### rtl/core/shp_front.sv
// Front end: accepts requests, classifies them and tracks the heading.
module shp_front #(
    parameter int unsigned FULL_TURN = shp_pkg::FULL_TURN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [8:0]        i_target_deg,
    input  logic [9:0]        i_joy_x,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [13:0]       i_cfg_step_angle,
    output shp_pkg::t_step_req o_req,
    output logic              o_push,
    input  logic              i_full
);
    import shp_pkg::*;

    localparam logic [15:0] FT   = 16'(FULL_TURN);
    localparam logic [14:0] HALF = 15'(FULL_TURN / 2);
    localparam logic [15:0] STEP_RST_MOD = mod_reduce({2'b0, STEP_ANGLE_RST}, FT);

    // Configuration: raw angle for arrival, reduced angle for stepping
    logic [13:0] r_step_angle;
    logic [14:0] r_step_mod;
    logic [15:0] cfg_mod;

    assign o_cfg_ready = 1'b1;
    assign cfg_mod     = mod_reduce({2'b0, i_cfg_step_angle}, FT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_angle <= STEP_ANGLE_RST;
            r_step_mod   <= STEP_RST_MOD[14:0];
        end else if (i_cfg_valid) begin
            r_step_angle <= i_cfg_step_angle;
            r_step_mod   <= cfg_mod[14:0];
        end
    end

    // Input stage: target reduction and joystick range decode
    logic        r_s1_v;
    logic        r_cmd;
    logic [14:0] r_target;
    logic        r_jstep;
    logic        r_jcw;
    logic [4:0]  r_jdwell;
    logic        s1_load;
    logic [15:0] tgt_mod;
    logic        n_jstep;
    logic        n_jcw;
    logic [4:0]  n_jdwell;

    assign s1_load    = !r_s1_v || !i_full;
    assign o_in_stall = r_s1_v && i_full;
    assign o_push     = r_s1_v && !i_full;
    assign tgt_mod    = mod_reduce(16'(i_target_deg) * DEG_SCALE, FT);

    always_comb begin
        n_jstep  = 1'b1;
        n_jcw    = 1'b0;
        n_jdwell = DWELL_FAST;
        priority if (i_joy_x >= JOY_CCW_SLOW_LO && i_joy_x <= JOY_CCW_SLOW_HI) begin
            n_jdwell = DWELL_SLOW;
        end else if (i_joy_x >= JOY_CCW_SLOW_HI) begin
            n_jdwell = DWELL_FAST;
        end else if (i_joy_x >= JOY_CW_SLOW_LO && i_joy_x <= JOY_CW_SLOW_HI) begin
            n_jcw    = 1'b1;
            n_jdwell = DWELL_SLOW;
        end else if (i_joy_x <= JOY_CW_SLOW_LO) begin
            n_jcw    = 1'b1;
        end else begin
            n_jstep  = 1'b0;
            n_jdwell = DWELL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_load) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_cmd    <= i_cmd;
            r_target <= tgt_mod[14:0];
            r_jstep  <= n_jstep;
            r_jcw    <= n_jcw;
            r_jdwell <= n_jdwell;
        end
    end

    // Classify stage: seek decision and heading update
    logic [14:0]        r_heading;
    logic [14:0]        n_heading;
    logic signed [15:0] diff;
    logic [14:0]        mag;
    logic               seek_arr;
    logic               seek_cw;
    logic [15:0]        sum_cw;
    logic [15:0]        sum_ccw;
    logic [14:0]        h_cw;
    logic [14:0]        h_ccw;
    t_step_req          req;

    assign diff     = signed'({1'b0, r_heading}) - signed'({1'b0, r_target});
    assign mag      = diff[15] ? 15'(-diff) : diff[14:0];
    assign seek_arr = mag <= {1'b0, r_step_angle};
    assign seek_cw  = diff[15] ? (mag <= HALF) : (mag > HALF);

    assign sum_cw  = {1'b0, r_heading} + {1'b0, r_step_mod};
    assign sum_ccw = {1'b0, r_heading} + FT - {1'b0, r_step_mod};
    assign h_cw    = (sum_cw  >= FT) ? 15'(sum_cw  - FT) : sum_cw[14:0];
    assign h_ccw   = (sum_ccw >= FT) ? 15'(sum_ccw - FT) : sum_ccw[14:0];

    always_comb begin
        if (r_cmd == CMD_JOY) begin
            req.is_step = r_jstep;
            req.cw      = r_jcw;
            req.dwell   = r_jdwell;
            req.arrived = 1'b0;
        end else begin
            req.is_step = !seek_arr;
            req.cw      = seek_cw;
            req.dwell   = seek_arr ? DWELL_NONE : DWELL_FAST;
            req.arrived = seek_arr;
        end
        if (req.is_step) begin
            n_heading = req.cw ? h_cw : h_ccw;
        end else begin
            n_heading = r_heading;
        end
        req.heading = n_heading;
    end

    assign o_req = req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else if (o_push) begin
            r_heading <= n_heading;
        end
    end

endmodule

### rtl/core/shp_queue.sv
// Short request queue between front end and phase sequencer.
module shp_queue #(
    parameter int unsigned DEPTH = shp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  shp_pkg::t_step_req i_req,
    output logic               o_full,
    input  logic               i_pop,
    output shp_pkg::t_step_req o_req,
    output logic               o_empty
);
    import shp_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_step_req        r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_req   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/shp_back.sv
// Back end: plays out coil phases into the output register.
module shp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shp_pkg::t_step_req i_req,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_coil_pattern,
    output logic [4:0]         o_dwell,
    output logic [14:0]        o_heading_out,
    output logic               o_arrived,
    output logic               o_last
);
    import shp_pkg::*;

    // Sequencer state
    logic        r_busy,    n_busy;
    logic [1:0]  r_phase,   n_phase;
    logic        r_cw,      n_cw;
    logic [4:0]  r_dw,      n_dw;
    logic [14:0] r_hd,      n_hd;

    // Output register
    logic        r_out_v,   n_out_v;
    logic [3:0]  r_coil,    n_coil;
    logic [4:0]  r_odw,     n_odw;
    logic [14:0] r_ohd,     n_ohd;
    logic        r_arr,     n_arr;
    logic        r_last,    n_last;
    logic        out_load;

    assign out_load = !r_out_v || !i_out_stall;

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_cw    = r_cw;
        n_dw    = r_dw;
        n_hd    = r_hd;
        n_out_v = r_out_v;
        n_coil  = r_coil;
        n_odw   = r_odw;
        n_ohd   = r_ohd;
        n_arr   = r_arr;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (out_load) begin
            if (r_busy) begin
                // remaining phases of the current step
                n_out_v = 1'b1;
                n_coil  = coil_seq(r_cw, r_phase);
                n_odw   = r_dw;
                n_ohd   = r_hd;
                n_arr   = 1'b0;
                n_last  = r_phase == PHASE_LAST;
                n_busy  = r_phase != PHASE_LAST;
                n_phase = r_phase + 1'b1;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_out_v = 1'b1;
                n_ohd   = i_req.heading;
                if (i_req.is_step) begin
                    n_coil  = coil_seq(i_req.cw, 2'd0);
                    n_odw   = i_req.dwell;
                    n_arr   = 1'b0;
                    n_last  = 1'b0;
                    n_busy  = 1'b1;
                    n_phase = 2'd1;
                    n_cw    = i_req.cw;
                    n_dw    = i_req.dwell;
                    n_hd    = i_req.heading;
                end else begin
                    // arrival or idle joystick: single result
                    n_coil  = COIL_OFF;
                    n_odw   = DWELL_NONE;
                    n_arr   = i_req.arrived;
                    n_last  = 1'b1;
                end
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw   <= n_cw;
        r_dw   <= n_dw;
        r_hd   <= n_hd;
        r_coil <= n_coil;
        r_odw  <= n_odw;
        r_ohd  <= n_ohd;
        r_arr  <= n_arr;
        r_last <= n_last;
    end

    assign o_out_valid    = r_out_v;
    assign o_coil_pattern = r_coil;
    assign o_dwell        = r_odw;
    assign o_heading_out  = r_ohd;
    assign o_arrived      = r_arr;
    assign o_last         = r_last;

endmodule

### rtl/core/stepper_heading_positioner_top.sv
// Top level of the stepper heading positioner.
//
//  Channel  | Direction | Handshake           | Carries
//  ---------+-----------+---------------------+-----------------------------------------
//  in       | input     | i_in_valid/o_in_stall   | cmd, target_deg, joy_x
//  out      | output    | o_out_valid/i_out_stall | coil_pattern, dwell, heading_out,
//           |           |                         | arrived, last
//  cfg      | input     | i_cfg_valid/o_cfg_ready | step_angle
//
// A request is taken every cycle while the queue has room. The output register
// delivers one result per cycle while not stalled: four for a stepping request,
// one for an arrival or idle joystick request. A request passes the input stage
// register, the queue and the output register. Synchronous active-low reset
// clears the heading to zero and the step angle to 70. A stall on the output backs
// up the queue and then stalls the input; the output payload holds while stalled.
module stepper_heading_positioner_top #(
    parameter int unsigned FULL_TURN   = shp_pkg::FULL_TURN_DEF,
    parameter int unsigned QUEUE_DEPTH = shp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [8:0]  i_target_deg,
    input  logic [9:0]  i_joy_x,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_step_angle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_coil_pattern,
    output logic [4:0]  o_dwell,
    output logic [14:0] o_heading_out,
    output logic        o_arrived,
    output logic        o_last
);
    import shp_pkg::*;

    t_step_req push_req;
    t_step_req pop_req;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;

    shp_front #(.FULL_TURN(FULL_TURN)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_target_deg     (i_target_deg),
        .i_joy_x          (i_joy_x),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_step_angle (i_cfg_step_angle),
        .o_req            (push_req),
        .o_push           (push),
        .i_full           (full)
    );

    shp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_req   (pop_req),
        .o_empty (empty)
    );

    shp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (pop_req),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coil_pattern (o_coil_pattern),
        .o_dwell        (o_dwell),
        .o_heading_out  (o_heading_out),
        .o_arrived      (o_arrived),
        .o_last         (o_last)
    );

endmodule

### rtl/core/shp_checker.sv
// Port-level checker for the stepper heading positioner, bound to the top level.
module shp_checker #(
    parameter int unsigned FULL_TURN = shp_pkg::FULL_TURN_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_coil_pattern,
    input logic [4:0]  o_dwell,
    input logic [14:0] o_heading_out,
    input logic        o_arrived,
    input logic        o_last
);
    import shp_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_coil_pattern)
            && $stable(o_dwell) && $stable(o_heading_out) && $stable(o_last))
        else $error("output changed while stalled");

    // Phases of one step follow without a gap
    a_phase_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("gap inside a step sequence");

    // A result without coil drive is a single, final, dwell-free result
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_coil_pattern == COIL_OFF) |-> o_last && (o_dwell == DWELL_NONE))
        else $error("no-step result malformed");

    // Stepping results drive one coil, carry a fast or slow dwell and never flag arrival
    a_step_coil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_coil_pattern != COIL_OFF) |-> $onehot(o_coil_pattern) && !o_arrived
            && (o_dwell == DWELL_FAST || o_dwell == DWELL_SLOW))
        else $error("bad stepping result");

    // Heading stays inside one turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_heading_out < 15'(FULL_TURN))
        else $error("heading out of range");

endmodule

bind stepper_heading_positioner_top shp_checker #(.FULL_TURN(FULL_TURN)) u_shp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_coil_pattern (o_coil_pattern),
    .o_dwell        (o_dwell),
    .o_heading_out  (o_heading_out),
    .o_arrived      (o_arrived),
    .o_last         (o_last)
);

### tb/tb_stepper_heading_positioner_top.sv
// Self-checking testbench for the stepper heading positioner: seek and joystick requests.
`timescale 1ns / 1ps

module tb_stepper_heading_positioner_top;
    import shp_pkg::*;

    localparam int TURN      = FULL_TURN_DEF;
    localparam int HALF_TURN = FULL_TURN_DEF / 2;
    localparam int MAX_GAP   = 13;
    localparam int HOLD_AT   = 120;       // result count that triggers the long hold-off
    localparam int HOLD_LEN  = 400;
    localparam int LIMIT     = 600000;
    localparam int N_JOY_EDGES = 14;

    // One seek or joystick request
    typedef struct {
        logic       cmd;
        logic [8:0] target_deg;
        logic [9:0] joy_x;
    } pos_req_t;

    // One coil phase result
    typedef struct {
        logic [3:0]  coil;
        logic [4:0]  dwell;
        logic [14:0] heading;
        logic        arrived;
        logic        last;
    } phase_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_cmd = CMD_SEEK;
    logic [8:0]  i_target_deg = '0;
    logic [9:0]  i_joy_x = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [13:0] i_cfg_step_angle = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_coil_pattern;
    logic [4:0]  o_dwell;
    logic [14:0] o_heading_out;
    logic        o_arrived;
    logic        o_last;

    stepper_heading_positioner_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_target_deg     (i_target_deg),
        .i_joy_x          (i_joy_x),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_step_angle (i_cfg_step_angle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_coil_pattern   (o_coil_pattern),
        .o_dwell          (o_dwell),
        .o_heading_out    (o_heading_out),
        .o_arrived        (o_arrived),
        .o_last           (o_last)
    );

    pos_req_t    pending_reqs[$];
    phase_t      pending_phases[$];
    pos_req_t    cur_req;
    phase_t      step_ph[4];
    logic [14:0] hdg_mdl = '0;
    logic [13:0] angle_mdl = STEP_ANGLE_RST;
    logic [14:0] gen_hdg = '0;
    int          n_ph;
    int          tx_wait = 0;
    int          rx_wait = 0;
    int          rx_cnt = 0;
    int          rx_gap;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    logic [9:0] joy_edges[N_JOY_EDGES] = '{
        10'h000, JOY_CW_SLOW_LO - 10'd1, JOY_CW_SLOW_LO, JOY_CW_SLOW_LO + 10'd1,
        JOY_CW_SLOW_HI - 10'd1, JOY_CW_SLOW_HI, JOY_CW_SLOW_HI + 10'd1,
        JOY_CCW_SLOW_LO - 10'd1, JOY_CCW_SLOW_LO, JOY_CCW_SLOW_LO + 10'd1,
        JOY_CCW_SLOW_HI - 10'd1, JOY_CCW_SLOW_HI, JOY_CCW_SLOW_HI + 10'd1, 10'h3FF
    };

    // Heading and coil phases produced by one request; updates the heading in place
    function automatic int predict_phases(input pos_req_t r, input logic [13:0] angle,
                                          inout logic [14:0] hdg, output phase_t ph[4]);
        int   tgt, diff, mag, s, h;
        logic do_step, cw, arr;
        logic [4:0] dw;
        do_step = 1'b1;
        cw      = 1'b0;
        arr     = 1'b0;
        dw      = DWELL_FAST;
        if (r.cmd == CMD_SEEK) begin
            tgt  = (int'(r.target_deg) * int'(DEG_SCALE)) % TURN;
            diff = int'(hdg) - tgt;
            mag  = (diff < 0) ? -diff : diff;
            if (mag <= int'(angle)) begin
                do_step = 1'b0;
                arr     = 1'b1;
            end else if (diff > 0) begin
                cw = (diff > HALF_TURN);
            end else begin
                cw = (diff >= -HALF_TURN);
            end
        end else if (r.joy_x >= JOY_CCW_SLOW_LO && r.joy_x <= JOY_CCW_SLOW_HI) begin
            dw = DWELL_SLOW;
        end else if (r.joy_x > JOY_CCW_SLOW_HI) begin
            dw = DWELL_FAST;
        end else if (r.joy_x >= JOY_CW_SLOW_LO && r.joy_x <= JOY_CW_SLOW_HI) begin
            cw = 1'b1;
            dw = DWELL_SLOW;
        end else if (r.joy_x < JOY_CW_SLOW_LO) begin
            cw = 1'b1;
        end else begin
            do_step = 1'b0;
        end

        // Arrival or dead zone: a single idle phase
        if (!do_step) begin
            ph[0] = '{COIL_OFF, DWELL_NONE, hdg, arr, 1'b1};
            return 1;
        end

        s = int'(angle) % TURN;
        h = int'(hdg) % TURN;
        hdg = cw ? 15'((h + s) % TURN) : 15'((h + TURN - s) % TURN);
        for (int k = 0; k < 4; k++) begin
            ph[k].dwell   = dw;
            ph[k].heading = hdg;
            ph[k].arrived = 1'b0;
            ph[k].last    = (k == 3);
        end
        // clockwise D A B C, counter-clockwise C B A D
        ph[0].coil = cw ? COIL_D : COIL_C;
        ph[1].coil = cw ? COIL_A : COIL_B;
        ph[2].coil = cw ? COIL_B : COIL_A;
        ph[3].coil = cw ? COIL_C : COIL_D;
        return 4;
    endfunction

    // Random wait between requests or results, with occasional switches into and out of back-to-back stretches
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 23) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // Queue a request and advance the generator's copy of the heading
    task automatic push_req(input logic cmd, input int tdeg, input int jx);
        pos_req_t    r;
        phase_t      ph[4];
        int          n;
        r.cmd        = cmd;
        r.target_deg = 9'(tdeg);
        r.joy_x      = 10'(jx);
        n = predict_phases(r, angle_mdl, gen_hdg, ph);
        pending_reqs.push_back(r);
    endtask

    // Wait until the block has drained every request and result
    task automatic settle();
        while (pending_reqs.size() != 0 || i_in_valid || pending_phases.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        gen_hdg = hdg_mdl;
    endtask

    task automatic write_step_angle(input logic [13:0] v);
        settle();
        i_cfg_valid      <= 1'b1;
        i_cfg_step_angle <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        angle_mdl = v;
        @(posedge i_clk);
    endtask

    // Mostly seek bursts toward one target, plus joystick and stray seeks
    task automatic gen_random(input int n_items);
        int cnt, kind, len, deg;
        cnt = 0;
        while (cnt < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 1) == 0) begin
                    deg = (int'(gen_hdg) / int'(DEG_SCALE) + 360 + $urandom_range(0, 4) - 2)
                          % 360;
                    if ($urandom_range(0, 3) == 0 && deg < 152) deg += 360;
                end else begin
                    deg = $urandom_range(0, 511);
                end
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) push_req(CMD_SEEK, deg, $urandom_range(0, 1023));
                cnt += len;
            end else if (kind <= 8) begin
                if ($urandom_range(0, 2) == 0)
                    push_req(CMD_JOY, $urandom_range(0, 511),
                             joy_edges[$urandom_range(0, N_JOY_EDGES - 1)]);
                else
                    push_req(CMD_JOY, $urandom_range(0, 511), $urandom_range(0, 1023));
                cnt++;
            end else begin
                push_req(CMD_SEEK, $urandom_range(0, 511), $urandom_range(0, 1023));
                cnt++;
            end
        end
    endtask

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Request driver: takes the next request from the queue after a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait    <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                n_ph = predict_phases(cur_req, angle_mdl, hdg_mdl, step_ph);
                for (int k = 0; k < n_ph; k++) pending_phases.push_back(step_ph[k]);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_wait > 0) begin
                    tx_wait    <= tx_wait - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req      = pending_reqs.pop_front();
                    i_cmd        <= cur_req.cmd;
                    i_target_deg <= cur_req.target_deg;
                    i_joy_x      <= cur_req.joy_x;
                    i_in_valid   <= 1'b1;
                    tx_wait      <= draw_gap(tx_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall, with one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait     <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (pending_phases.size() == 0) begin
                $error("unexpected result: coil %0h heading %0d", o_coil_pattern,
                       o_heading_out);
                mismatch_cnt++;
            end else begin
                step_ph[0] = pending_phases.pop_front();
                check_field("coil_pattern", step_ph[0].coil, o_coil_pattern);
                check_field("dwell", step_ph[0].dwell, o_dwell);
                check_field("heading_out", step_ph[0].heading, o_heading_out);
                check_field("arrived", step_ph[0].arrived, o_arrived);
                check_field("last", step_ph[0].last, o_last);
            end
            rx_cnt++;
            rx_gap = (rx_cnt == HOLD_AT) ? HOLD_LEN : draw_gap(rx_quiet);
            rx_wait     <= rx_gap;
            i_out_stall <= (rx_gap != 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_stall <= (rx_wait > 1);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: heading 0, reset step angle
        push_req(CMD_SEEK, 0, 0);      // exact arrival
        push_req(CMD_SEEK, 359, 0);    // short way crosses zero downward
        push_req(CMD_SEEK, 359, 0);    // within one step
        push_req(CMD_SEEK, 0, 0);      // short way crosses zero upward
        push_req(CMD_SEEK, 180, 0);    // exactly half a turn away
        push_req(CMD_SEEK, 511, 1023); // target beyond one turn
        push_req(CMD_SEEK, 360, 0);    // a full turn reduces to zero
        push_req(CMD_SEEK, 1, 0);
        push_req(CMD_SEEK, 356, 0);    // raw distance, not wrapped
        for (int k = 0; k < N_JOY_EDGES; k++) push_req(CMD_JOY, 511, joy_edges[k]);
        gen_random(200);

        write_step_angle(14'd16200);
        gen_random(50);
        write_step_angle(14'h3FFF);
        gen_random(35);

        // Zero step angle: phases still run, heading stays
        write_step_angle(14'd0);
        push_req(CMD_SEEK, 90, 0);
        push_req(CMD_SEEK, 270, 0);
        push_req(CMD_JOY, 0, 10'h000);
        push_req(CMD_JOY, 0, 10'h3FF);
        gen_random(25);

        write_step_angle(14'd1);
        gen_random(45);
        write_step_angle(14'($urandom_range(1, 16383)));
        gen_random(40);
        write_step_angle(14'($urandom_range(1, 900)));
        gen_random(40);
        write_step_angle(STEP_ANGLE_RST);
        gen_random(30);

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/shp_pkg.sv
rtl/core/shp_front.sv
rtl/core/shp_queue.sv
rtl/core/shp_back.sv
rtl/core/stepper_heading_positioner_top.sv
rtl/core/shp_checker.sv
tb/tb_stepper_heading_positioner_top.sv
